// File: rtl/single_wire_sensor_bit_decoder_macros.svh
// ----------------------------------------------------------------------------
// single_wire_sensor_bit_decoder_macros
// assertion macros shared by the decoder modules
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_SENSOR_BIT_DECODER_MACROS_SVH
`define SINGLE_WIRE_SENSOR_BIT_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define SWSBD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define SWSBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SWSBD_ASSERT(lbl, clk, rst, prop)
`define SWSBD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/swsbd_pkg.sv
// ----------------------------------------------------------------------------
// swsbd_pkg
// types and constants of the single-wire sensor bit decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swsbd_pkg;

  localparam int FRAME_BITS_DEF = 40;
  localparam int QUEUE_DEPTH    = 2;

  localparam int TICK_W   = 16;
  localparam int DUTY_W   = 7;
  localparam int SKIP_W   = 3;
  localparam int NUM_W    = TICK_W + DUTY_W;
  localparam int DIV_STEPS = DUTY_W;
  localparam int STEP_W   = $clog2(DIV_STEPS);
  localparam int BYTE_W   = 8;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;

  localparam logic [SKIP_W-1:0] SKIP_RST     = 3'd2;
  localparam logic [DUTY_W-1:0] ONE_MIN_RST  = 7'd50;
  localparam logic [DUTY_W-1:0] ONE_MAX_RST  = 7'd60;
  localparam logic [DUTY_W-1:0] ZERO_MIN_RST = 7'd25;
  localparam logic [DUTY_W-1:0] ZERO_MAX_RST = 7'd35;

  typedef enum logic [2:0] {
    REG_SKIP     = 3'd0,
    REG_ONE_MIN  = 3'd1,
    REG_ONE_MAX  = 3'd2,
    REG_ZERO_MIN = 3'd3,
    REG_ZERO_MAX = 3'd4
  } reg_idx_t;

  typedef logic [DUTY_W-1:0] duty_t;

  typedef struct packed {
    logic [TICK_W-1:0] period_ticks;
    logic [TICK_W-1:0] high_ticks;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] humidity;
    logic [BYTE_W-1:0] temperature;
    logic [BYTE_W-1:0] parity_byte;
    logic              bad_bit_seen;
  } out_item_t;

  typedef struct packed {
    logic [SKIP_W-1:0] skip_pulses;
    duty_t             one_duty_min;
    duty_t             one_duty_max;
    duty_t             zero_duty_min;
    duty_t             zero_duty_max;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/swsbd_front.sv
// ----------------------------------------------------------------------------
// swsbd_front
// accepts captures, drops invalid ones, computes the saturated duty percent
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "single_wire_sensor_bit_decoder_macros.svh"

module swsbd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire swsbd_pkg::in_item_t pulse,
  output logic                    q_push,
  output swsbd_pkg::duty_t        q_data,
  input  wire logic               q_full
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_PUSH} state_t;

  state_t                              state;
  logic [swsbd_pkg::TICK_W-1:0]        period;
  logic [swsbd_pkg::TICK_W-1:0]        high;
  logic [swsbd_pkg::NUM_W-1:0]         num;
  logic [swsbd_pkg::STEP_W-1:0]        step;
  swsbd_pkg::duty_t                    quo;
  logic [swsbd_pkg::NUM_W-1:0]         divisor;
  logic                                accept;

  assign full    = (state != S_IDLE);
  assign accept  = push && !full;
  assign divisor = swsbd_pkg::NUM_W'(period) << step;
  assign q_push  = (state == S_PUSH) && !q_full;
  assign q_data  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (pulse.period_ticks != '0) && (pulse.high_ticks != '0)) begin
            period <= pulse.period_ticks;
            high   <= pulse.high_ticks;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          num  <= swsbd_pkg::NUM_W'(high) * swsbd_pkg::NUM_W'(swsbd_pkg::DUTY_FULL);
          step <= swsbd_pkg::STEP_W'(swsbd_pkg::DIV_STEPS - 1);
          // high time at or above the period saturates at full duty
          if (high >= period) begin
            quo   <= swsbd_pkg::DUTY_FULL;
            state <= S_PUSH;
          end else begin
            quo   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (num >= divisor) begin
            num       <= num - divisor;
            quo[step] <= 1'b1;
          end
          if (step == '0) begin
            state <= S_PUSH;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_PUSH: begin
          if (!q_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SWSBD_ASSERT(a_duty_range, clk, rst, (state != S_PUSH) || (quo <= swsbd_pkg::DUTY_FULL))
  `SWSBD_ASSERT(a_rem_bound, clk, rst, (state != S_DIV) || ((swsbd_pkg::NUM_W + 1)'(num) < ((swsbd_pkg::NUM_W + 1)'(period) << (step + 1))))
  `SWSBD_ASSERT_NEXT(a_drop_invalid, clk, rst, accept && ((pulse.period_ticks == '0) || (pulse.high_ticks == '0)), state == S_IDLE)

endmodule

`default_nettype wire

// File: rtl/swsbd_fifo.sv
// ----------------------------------------------------------------------------
// swsbd_fifo
// short queue of duty values between the front and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swsbd_fifo #(
  parameter int WIDTH = swsbd_pkg::DUTY_W,
  parameter int DEPTH = swsbd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/swsbd_back.sv
// ----------------------------------------------------------------------------
// swsbd_back
// skips leading pulses, classifies bits, assembles the frame and holds the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "single_wire_sensor_bit_decoder_macros.svh"

module swsbd_back #(
  parameter int FRAME_BITS = swsbd_pkg::FRAME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire swsbd_pkg::cfg_t      cfg,
  input  wire logic                 q_empty,
  input  wire swsbd_pkg::duty_t     q_data,
  output logic                      q_pop,
  output logic                      empty,
  input  wire logic                 pop,
  output swsbd_pkg::out_item_t      result
);

  localparam int IDX_W = $clog2(FRAME_BITS);

  logic [swsbd_pkg::SKIP_W-1:0] pulse_count;
  logic [IDX_W-1:0]             bit_index;
  logic [FRAME_BITS-1:0]        bit_shift;
  logic [FRAME_BITS-1:0]        bit_shift_next;
  logic                         bad_flag;
  logic                         out_valid;
  logic                         in_skip;
  logic                         last;
  logic                         bit_one;
  logic                         bit_zero;
  logic                         out_load;

  assign in_skip  = pulse_count < cfg.skip_pulses;
  assign last     = (bit_index == IDX_W'(FRAME_BITS - 1));
  assign bit_one  = (q_data >= cfg.one_duty_min) && (q_data <= cfg.one_duty_max);
  assign bit_zero = (q_data >= cfg.zero_duty_min) && (q_data <= cfg.zero_duty_max);
  assign bit_shift_next = {bit_shift[FRAME_BITS-2:0], bit_one};

  // frame end waits until the held result is taken
  assign q_pop    = !q_empty && (in_skip || !last || !out_valid || pop);
  assign out_load = q_pop && !in_skip && last;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= '0;
      bit_index   <= '0;
      bit_shift   <= '0;
      bad_flag    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        if (in_skip) begin
          pulse_count <= pulse_count + 1'b1;
        end else if (last) begin
          result.humidity     <= bit_shift_next[FRAME_BITS-1 -: swsbd_pkg::BYTE_W];
          result.temperature  <= bit_shift_next[FRAME_BITS-17 -: swsbd_pkg::BYTE_W];
          result.parity_byte  <= bit_shift_next[FRAME_BITS-33 -: swsbd_pkg::BYTE_W];
          result.bad_bit_seen <= bad_flag || (!bit_one && !bit_zero);
          pulse_count <= '0;
          bit_index   <= '0;
          bit_shift   <= '0;
          bad_flag    <= 1'b0;
        end else begin
          bit_shift <= bit_shift_next;
          bit_index <= bit_index + 1'b1;
          bad_flag  <= bad_flag || (!bit_one && !bit_zero);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SWSBD_ASSERT(a_no_overwrite, clk, rst, !out_load || !out_valid || pop)
  `SWSBD_ASSERT(a_index_range, clk, rst, bit_index <= IDX_W'(FRAME_BITS - 1))
  `SWSBD_ASSERT_NEXT(a_frame_clear, clk, rst, out_load, (bit_index == '0) && !bad_flag && (pulse_count == '0) && !empty)

endmodule

`default_nettype wire

// File: rtl/single_wire_sensor_bit_decoder.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_bit_decoder
// decodes captured sensor pulses into humidity, temperature and parity bytes
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  pulse     in         push / full               period_ticks, high_ticks
//  result    out        empty / pop               humidity, temperature, parity_byte, bad_bit_seen
//  config    in         psel / penable / pready   five registers at 4*i
//
//  a valid capture runs multiply, 7 divide steps, then queue push; full stays high until the push
//  a high time at or above the period skips the divide and goes from multiply straight to queue push
//  a capture with a zero field is dropped in its accept cycle
//  the back part takes one queued duty value per cycle, except at frame end while the result is not yet taken
//  synchronous reset restores default windows and clears the frame
//  frame end stalls while the previous result is not yet taken; the front stalls on a full queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module single_wire_sensor_bit_decoder #(
  parameter int FRAME_BITS = swsbd_pkg::FRAME_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire swsbd_pkg::in_item_t              pulse,
  output logic                                  empty,
  input  wire logic                             pop,
  output swsbd_pkg::out_item_t                  result,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [swsbd_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [swsbd_pkg::DATA_W-1:0]     pwdata,
  output logic [swsbd_pkg::DATA_W-1:0]          prdata,
  output logic                                  pready
);

  swsbd_pkg::cfg_t  cfg;
  logic             wr_en;
  logic [2:0]       reg_idx;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  swsbd_pkg::duty_t q_wdata;
  swsbd_pkg::duty_t q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_pulses   <= swsbd_pkg::SKIP_RST;
      cfg.one_duty_min  <= swsbd_pkg::ONE_MIN_RST;
      cfg.one_duty_max  <= swsbd_pkg::ONE_MAX_RST;
      cfg.zero_duty_min <= swsbd_pkg::ZERO_MIN_RST;
      cfg.zero_duty_max <= swsbd_pkg::ZERO_MAX_RST;
    end else if (wr_en) begin
      case (reg_idx)
        swsbd_pkg::REG_SKIP:     cfg.skip_pulses   <= pwdata[swsbd_pkg::SKIP_W-1:0];
        swsbd_pkg::REG_ONE_MIN:  cfg.one_duty_min  <= pwdata[swsbd_pkg::DUTY_W-1:0];
        swsbd_pkg::REG_ONE_MAX:  cfg.one_duty_max  <= pwdata[swsbd_pkg::DUTY_W-1:0];
        swsbd_pkg::REG_ZERO_MIN: cfg.zero_duty_min <= pwdata[swsbd_pkg::DUTY_W-1:0];
        swsbd_pkg::REG_ZERO_MAX: cfg.zero_duty_max <= pwdata[swsbd_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      swsbd_pkg::REG_SKIP:     prdata = swsbd_pkg::DATA_W'(cfg.skip_pulses);
      swsbd_pkg::REG_ONE_MIN:  prdata = swsbd_pkg::DATA_W'(cfg.one_duty_min);
      swsbd_pkg::REG_ONE_MAX:  prdata = swsbd_pkg::DATA_W'(cfg.one_duty_max);
      swsbd_pkg::REG_ZERO_MIN: prdata = swsbd_pkg::DATA_W'(cfg.zero_duty_min);
      swsbd_pkg::REG_ZERO_MAX: prdata = swsbd_pkg::DATA_W'(cfg.zero_duty_max);
      default:                 prdata = '0;
    endcase
  end

  swsbd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .pulse  (pulse),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  swsbd_fifo #(
    .WIDTH (swsbd_pkg::DUTY_W),
    .DEPTH (swsbd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  swsbd_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire
